// ===== hw/rtl/sensor_table_linearizer_macros.svh =====
// Assertion macros shared by the sensor table linearizer RTL.
`ifndef SENSOR_TABLE_LINEARIZER_MACROS_SVH
`define SENSOR_TABLE_LINEARIZER_MACROS_SVH
`ifndef SYNTH
`define STL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sensor_table_linearizer: assertion failed");
`define STL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sensor_table_linearizer: assertion failed");
`else
`define STL_ASSERT_IMP(lbl, ante, cons)
`define STL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/stl_pkg.sv =====
// Types and constants shared by the sensor table linearizer files.
`timescale 1ns / 1ps

package stl_pkg;

  localparam int STL_POINTS = 11;

  localparam int RAW_W  = 16;
  localparam int IDX_W  = 4;
  localparam int DIST_W = 16;
  localparam int CUR_W  = 13;
  localparam int PCT_W  = 15;
  localparam int DAC_W  = 16;
  localparam int SEG_W  = 4;

  // The top four bits of a sensor word are error flags.
  localparam int ERR_BITS = 4;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  localparam int DIST_MAX    = 32767;
  localparam int DIST_MIN    = -32768;
  localparam int CUR_LO      = 1024;
  localparam int CUR_HI      = 5120;
  localparam int CUR_SPAN_Q8 = 4096;

  // DAC word: (5*I - 4864)*65535/22016, with 22016 = 43 * 2^9.
  localparam int DAC_X_OFS = 256;
  localparam int DAC_SHIFT = 9;
  localparam int DAC_DIV   = 43;
  localparam int DAC_PRE_W = 22;

  typedef struct packed {
    logic             cmd;
    logic [RAW_W-1:0] raw_word;
    logic [IDX_W-1:0] point_index;
  } stl_in_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance_q8;
    logic [CUR_W-1:0]         current_q8;
    logic [PCT_W-1:0]         percent_q8;
    logic [DAC_W-1:0]         dac_code;
    logic [SEG_W-1:0]         segment;
    logic                     sample_held;
    logic                     flat_segment;
  } stl_out_t;

endpackage

// ===== hw/rtl/stl_channels.sv =====
// Valid/ready channel interfaces for the linearizer input and result streams.
`timescale 1ns / 1ps

interface stl_in_if;
  logic            valid;
  logic            ready;
  stl_pkg::stl_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stl_out_if;
  logic             valid;
  logic             ready;
  stl_pkg::stl_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sensor_table_linearizer.sv =====
// Top level of the sensor table linearizer: table walk, serial divider and output stage.
`timescale 1ns / 1ps
`include "sensor_table_linearizer_macros.svh"

// The linearizer maps a raw inductive-sensor word onto distance through a
// descending calibration table of POINTS entries, one entry per millimeter,
// and derives a 4-20 mA loop current, a percent of span and a DAC code from it.
// A transaction with cmd = write stores raw_word into table entry point_index
// (indexes not below POINTS are dropped) and produces no result. A sample
// transaction produces exactly one result; when any of its four error bits is
// set, the last good sample is used again and sample_held is raised. Table
// entries must be written before a sample can reach them. The block works on
// one sample at a time: it scans the table until an entry not above the sample
// or the last entry is found, reads the two entries of that segment, forms the
// slope and the numerator, runs the position division, applies the sign and
// clamps, then scales the current by 1/(POINTS-1) in a second division, which
// is skipped when the current clamps at 4 or 20 mA, and forms the DAC code in
// a third division. The single radix-2 restoring divider produces one quotient
// bit per cycle and is reused for the position, the current and the DAC code.
// The result sits in an output register, so the next transaction is taken
// while a finished result still waits for the sink.

module sensor_table_linearizer #(
  parameter int POINTS = stl_pkg::STL_POINTS
) (
  input  logic          clk,
  input  logic          rst_n,
  stl_in_if.sink        in_ch,
  stl_out_if.source     out_ch
);

  import stl_pkg::*;

  // Index width for table entries and segment numbers.
  localparam int KW   = $clog2(POINTS);
  // Signed position numerator and the left-aligned dividend width.
  localparam int NW   = KW + 18;
  localparam int DW   = KW + 29;
  localparam int QBW  = DW + 2;
  localparam int CW   = $clog2(DW + 1);
  // Current scaling: quotient of 4096*n/d is clamped below this bound.
  localparam int CMAX = CUR_SPAN_Q8 * (POINTS - 1);
  localparam int QW   = $clog2(CMAX);
  localparam logic [KW-1:0] LAST = KW'(POINTS - 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SEARCH = 4'd1;
  localparam logic [3:0] ST_RD_LO  = 4'd2;
  localparam logic [3:0] ST_RD_HI  = 4'd3;
  localparam logic [3:0] ST_CALC_D = 4'd4;
  localparam logic [3:0] ST_CALC_N = 4'd5;
  localparam logic [3:0] ST_DIV_Q  = 4'd6;
  localparam logic [3:0] ST_FIX_Q  = 4'd7;
  localparam logic [3:0] ST_CLAMP  = 4'd8;
  localparam logic [3:0] ST_DIV_C  = 4'd9;
  localparam logic [3:0] ST_LD_DAC = 4'd10;
  localparam logic [3:0] ST_DIV_D  = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  // Calibration table, written from the input channel, read one entry a cycle.
  logic [RAW_W-1:0] table_mem [POINTS];
  logic [RAW_W-1:0] rd_data_r;
  logic [KW-1:0]    rd_addr;
  logic             wr_en;

  logic [3:0]              state_r, state_nxt;
  logic [KW-1:0]           k_r;
  logic [RAW_W-1:0]        held_r;
  logic                    held_flag_r;
  logic [RAW_W-1:0]        x1_r;
  logic signed [RAW_W:0]   d_r;
  logic                    flat_r;
  logic                    neg_r;
  logic [DW-1:0]           div_r;
  logic [RAW_W-1:0]        rem_r;
  logic [RAW_W-1:0]        dvs_r;
  logic [CW-1:0]           cnt_r;
  logic signed [QBW-1:0]   q_r;
  logic signed [DIST_W-1:0] dist_r;
  logic [CUR_W-1:0]        cur_off_r;
  stl_out_t                out_data_r;
  logic                    out_valid_r;

  logic                    in_ready;
  logic                    in_take;
  logic                    out_load;
  logic                    search_hit;

  // Divider step.
  logic [RAW_W:0]          trial;
  logic                    trial_ge;
  logic [RAW_W:0]          trial_diff;

  // Arithmetic between divider runs.
  logic signed [RAW_W:0]   d_calc;
  logic [KW-1:0]           km1;
  logic signed [NW-1:0]    n_calc;
  logic signed [NW-1:0]    n_abs;
  logic signed [RAW_W:0]   d_abs;
  logic [DW:0]             q_mag;
  logic signed [QBW-1:0]   q_sig;
  logic signed [QBW-1:0]   q_shr;
  logic [14:0]             dac_x;
  logic [30:0]             dac_prod;
  logic [16:0]             pct_x25;

  assign in_ready     = (state_r == ST_IDLE);
  assign in_ch.ready  = in_ready;
  assign in_take      = in_ch.valid && in_ready;
  assign wr_en        = in_take && (in_ch.data.cmd == CMD_WRITE) &&
                        (int'(in_ch.data.point_index) < POINTS);
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign search_hit = (rd_data_r <= held_r) || (k_r == LAST);

  always_comb begin
    unique case (state_r)
      ST_SEARCH: rd_addr = (k_r == LAST) ? k_r : k_r + KW'(1);
      ST_RD_LO:  rd_addr = k_r - KW'(1);
      ST_IDLE:   rd_addr = '0;
      default:   rd_addr = k_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[KW'(in_ch.data.point_index)] <= in_ch.data.raw_word;
    end
    rd_data_r <= table_mem[rd_addr];
  end

  always_comb begin
    trial      = {rem_r, div_r[DW-1]};
    trial_ge   = (trial >= {1'b0, dvs_r});
    trial_diff = trial - {1'b0, dvs_r};

    d_calc = $signed({1'b0, rd_data_r}) - $signed({1'b0, x1_r});
    km1    = k_r - KW'(1);
    if (flat_r) begin
      n_calc = $signed(NW'(km1));
    end else begin
      n_calc = $signed({1'b0, km1}) * d_r +
               ($signed({1'b0, held_r}) - $signed({1'b0, x1_r}));
    end
    n_abs = n_calc[NW-1] ? -n_calc : n_calc;
    d_abs = d_r[RAW_W] ? -d_r : d_r;

    // Floor for a negative quotient rounds the magnitude up on a remainder.
    q_mag = {1'b0, div_r} + (DW+1)'(neg_r && (rem_r != '0));
    q_sig = $signed({1'b0, q_mag});
    q_shr = q_r >>> 4;

    dac_x    = {cur_off_r, 2'b00} + 15'(cur_off_r) + 15'(DAC_X_OFS);
    dac_prod = {dac_x, 16'h0000} - {16'h0000, dac_x};
    pct_x25  = {cur_off_r, 4'b0000} + {1'b0, cur_off_r, 3'b000} + 17'(cur_off_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take && (in_ch.data.cmd == CMD_SAMPLE)) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (search_hit) begin
          state_nxt = ST_RD_LO;
        end
      end
      ST_RD_LO:  state_nxt = ST_RD_HI;
      ST_RD_HI:  state_nxt = ST_CALC_D;
      ST_CALC_D: state_nxt = ST_CALC_N;
      ST_CALC_N: state_nxt = ST_DIV_Q;
      ST_DIV_Q: begin
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_FIX_Q;
        end
      end
      ST_FIX_Q:  state_nxt = ST_CLAMP;
      ST_CLAMP: begin
        if (q_r[QBW-1] || (q_r >= $signed(QBW'(CMAX)))) begin
          state_nxt = ST_LD_DAC;
        end else begin
          state_nxt = ST_DIV_C;
        end
      end
      ST_DIV_C: begin
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_LD_DAC;
        end
      end
      ST_LD_DAC: state_nxt = ST_DIV_D;
      ST_DIV_D: begin
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_take && (in_ch.data.cmd == CMD_SAMPLE) &&
          (in_ch.data.raw_word[RAW_W-1 -: ERR_BITS] == '0)) begin
        held_r <= in_ch.data.raw_word;
      end
    end
  end

  // Datapath: table walk, serial divider and result assembly.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        k_r         <= '0;
        held_flag_r <= (in_ch.data.raw_word[RAW_W-1 -: ERR_BITS] != '0);
      end
      ST_SEARCH: begin
        if (search_hit) begin
          k_r <= (k_r == '0) ? KW'(1) : k_r;
        end else begin
          k_r <= k_r + KW'(1);
        end
      end
      ST_RD_LO: begin
      end
      ST_RD_HI: begin
        x1_r <= rd_data_r;
      end
      ST_CALC_D: begin
        flat_r <= (rd_data_r == x1_r);
        d_r    <= (rd_data_r == x1_r) ? 17'sd1 : d_calc;
      end
      ST_CALC_N: begin
        neg_r <= n_calc[NW-1] ^ d_r[RAW_W];
        div_r <= {n_abs[NW-2:0], 12'h000};
        dvs_r <= d_abs[RAW_W-1:0];
        rem_r <= '0;
        cnt_r <= CW'(DW);
      end
      ST_DIV_Q, ST_DIV_C, ST_DIV_D: begin
        rem_r <= trial_ge ? trial_diff[RAW_W-1:0] : trial[RAW_W-1:0];
        div_r <= {div_r[DW-2:0], trial_ge};
        cnt_r <= cnt_r - CW'(1);
        if ((state_r == ST_DIV_C) && (cnt_r == CW'(1))) begin
          cur_off_r <= {div_r[CUR_W-2:0], trial_ge};
        end
      end
      ST_FIX_Q: begin
        q_r <= neg_r ? -q_sig : q_sig;
      end
      ST_CLAMP: begin
        if (q_shr > $signed(QBW'(DIST_MAX))) begin
          dist_r <= DIST_W'(DIST_MAX);
        end else if (q_shr < $signed(QBW'(DIST_MIN))) begin
          dist_r <= DIST_W'(DIST_MIN);
        end else begin
          dist_r <= q_shr[DIST_W-1:0];
        end
        if (q_r[QBW-1]) begin
          cur_off_r <= '0;
        end else if (q_r >= $signed(QBW'(CMAX))) begin
          cur_off_r <= CUR_W'(CUR_SPAN_Q8);
        end else begin
          // Scale by 1/(POINTS-1): the QW-bit dividend is left-aligned.
          div_r <= DW'(q_r[QW-1:0]) << (DW - QW);
          dvs_r <= RAW_W'(POINTS - 1);
          rem_r <= '0;
          cnt_r <= CW'(QW);
        end
      end
      ST_LD_DAC: begin
        div_r <= DW'(dac_prod[30:DAC_SHIFT]) << (DW - DAC_PRE_W);
        dvs_r <= RAW_W'(DAC_DIV);
        rem_r <= '0;
        cnt_r <= CW'(DAC_PRE_W);
      end
      ST_DONE: begin
        if (out_load) begin
          out_data_r.distance_q8  <= dist_r;
          out_data_r.current_q8   <= CUR_W'(CUR_LO) + cur_off_r;
          out_data_r.percent_q8   <= pct_x25[16:2];
          out_data_r.dac_code     <= div_r[DAC_W-1:0];
          out_data_r.segment      <= SEG_W'(k_r);
          out_data_r.sample_held  <= held_flag_r;
          out_data_r.flat_segment <= flat_r;
        end
      end
      default: begin
      end
    endcase
  end

  `STL_ASSERT_IMP(a_seg_nonzero, state_r == ST_DONE, k_r != '0)
  `STL_ASSERT_IMP(a_div_count, (state_r == ST_DIV_Q) || (state_r == ST_DIV_C) || (state_r == ST_DIV_D), cnt_r != '0)
  `STL_ASSERT_NXT(a_sample_walk, in_take && (in_ch.data.cmd == CMD_SAMPLE), state_r == ST_SEARCH)
  `STL_ASSERT_IMP(a_cur_range, out_valid_r, (out_data_r.current_q8 >= CUR_W'(CUR_LO)) && (out_data_r.current_q8 <= CUR_W'(CUR_HI)))
  `STL_ASSERT_NXT(a_out_load, out_load, out_valid_r && (state_r == ST_IDLE))

endmodule
